// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define KCAC_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define KCAC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: hdl/kcac_pkg.sv
// ----------------------------------------------------------------------------
// kcac_pkg
// Types, constants and helpers of the keypad code alarm controller.
// ----------------------------------------------------------------------------
`default_nettype none

package kcac_pkg;

  localparam int unsigned CodeDigits = 4;
  localparam int unsigned CntW       = $clog2(CodeDigits + 1);
  localparam int unsigned KeyW       = 4;
  localparam int unsigned CodeW      = 16;
  localparam int unsigned PulseW     = 9;
  localparam int unsigned LimitW     = 8;
  localparam int unsigned DigitsW    = 3;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [KeyW-1:0] KeyStar = 4'd10;
  localparam logic [KeyW-1:0] KeyHash = 4'd11;
  localparam logic [KeyW-1:0] KeyNone = 4'd15;

  localparam logic [CfgIdxW-1:0] CfgSecretCode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgArmPulses  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPollLimit  = 2'd2;

  localparam logic [CodeW-1:0]  SecretCodeRst = 16'd4696;
  localparam logic [LimitW-1:0] ArmPulsesRst  = 8'd29;
  localparam logic [LimitW-1:0] PollLimitRst  = 8'd50;

  typedef enum logic [2:0] {
    ModeEntry  = 3'd0,
    ModeArming = 3'd1,
    ModeArmed  = 3'd2,
    ModeBreach = 3'd3,
    ModeSiren  = 3'd4,
    ModeHalt   = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    MsgNone     = 3'd0,
    MsgAccepted = 3'd1,
    MsgWrong    = 3'd2,
    MsgBreach   = 3'd3,
    MsgDisarmed = 3'd4
  } msg_e;

  typedef enum logic [1:0] {
    VerdictNone  = 2'd0,
    VerdictMatch = 2'd1,
    VerdictWrong = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [CodeW-1:0]  secret_code;
    logic [LimitW-1:0] arm_pulses;
    logic [LimitW-1:0] breach_poll_limit;
  } cfg_t;

  typedef struct packed {
    logic take;
    logic clear;
  } entry_ctl_t;

  typedef struct packed {
    verdict_e        verdict;
    logic [CntW-1:0] count;
  } entry_stat_t;

  typedef struct packed {
    mode_e              mode;
    logic               alarm_lamp;
    logic               zone_lamps;
    logic               low_buzzer;
    logic               high_buzzer;
    logic               serial_alarm;
    msg_e               message;
    logic [DigitsW-1:0] digits_entered;
  } result_t;

  // code digit i, first digit in the top nibble of the used span
  function automatic logic [KeyW-1:0] code_digit(logic [CodeW-1:0] code, int unsigned i);
    int unsigned      shift;
    logic [CodeW-1:0] tmp;
    shift = 4 * (CodeDigits - 1 - i);
    tmp   = code >> shift;
    if (shift >= CodeW) begin
      return '0;
    end
    return tmp[KeyW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hdl/kcac_intf.sv
// ----------------------------------------------------------------------------
// kcac_intf
// Poll, result and configuration channels of the alarm controller.
// ----------------------------------------------------------------------------
`default_nettype none

interface kcac_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] key;
  logic       motion_sensor;
  logic       door_sensor;

  modport source (output valid, key, motion_sensor, door_sensor, input ready);
  modport sink   (input valid, key, motion_sensor, door_sensor, output ready);
endinterface

interface kcac_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic       alarm_lamp;
  logic       zone_lamps;
  logic       low_buzzer;
  logic       high_buzzer;
  logic       serial_alarm;
  logic [2:0] message;
  logic [2:0] digits_entered;

  modport source (output valid, mode, alarm_lamp, zone_lamps, low_buzzer, high_buzzer,
                  serial_alarm, message, digits_entered, input ready);
  modport sink   (input valid, mode, alarm_lamp, zone_lamps, low_buzzer, high_buzzer,
                  serial_alarm, message, digits_entered, output ready);
endinterface

interface kcac_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/kcac_cfg_regs.sv
// ----------------------------------------------------------------------------
// kcac_cfg_regs
// Configuration registers: secret code, exit pulses and breach poll budget.
// ----------------------------------------------------------------------------
`default_nettype none

module kcac_cfg_regs
  import kcac_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  kcac_cfg_if.sink   cfg_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgSecretCode: cfg_d.secret_code       = cfg_i.data;
        CfgArmPulses:  cfg_d.arm_pulses        = cfg_i.data[LimitW-1:0];
        CfgPollLimit:  cfg_d.breach_poll_limit = cfg_i.data[LimitW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.secret_code       <= SecretCodeRst;
      cfg_q.arm_pulses        <= ArmPulsesRst;
      cfg_q.breach_poll_limit <= PollLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: hdl/kcac_entry.sv
// ----------------------------------------------------------------------------
// kcac_entry
// Code entry buffer: stores keys, counts them and checks a star request.
// ----------------------------------------------------------------------------
`default_nettype none

module kcac_entry
  import kcac_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire entry_ctl_t      ctl_i,
  input  wire logic [KeyW-1:0] key_i,
  input  wire logic [CodeW-1:0] secret_code_i,
  output entry_stat_t          stat_o
);

  logic [KeyW-1:0] digits_q [CodeDigits];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            wr;
  logic            match;
  verdict_e        verdict;

  always_comb begin
    match = 1'b1;
    for (int unsigned i = 0; i < CodeDigits; i++) begin
      if (digits_q[i] != code_digit(secret_code_i, i)) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    cnt_d   = cnt_q;
    wr      = 1'b0;
    verdict = VerdictNone;
    if (ctl_i.clear) begin
      cnt_d = '0;
    end else if (ctl_i.take && key_i != KeyNone) begin
      if (key_i == KeyHash) begin
        cnt_d = '0;
      end else if (cnt_q >= CntW'(CodeDigits)) begin
        cnt_d = '0;
        if (key_i == KeyStar) begin
          verdict = match ? VerdictMatch : VerdictWrong;
        end
      end else begin
        wr    = 1'b1;
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int unsigned i = 0; i < CodeDigits; i++) begin
      if (wr && cnt_q == CntW'(i)) begin
        digits_q[i] <= key_i;
      end
    end
  end

  assign stat_o.verdict = verdict;
  assign stat_o.count   = cnt_d;

endmodule

`default_nettype wire

// File: hdl/kcac_ctrl.sv
// ----------------------------------------------------------------------------
// kcac_ctrl
// Mode sequencer: exit blink count, armed watch, breach budget, siren.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module kcac_ctrl
  import kcac_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        fire_i,
  input  wire logic        sensed_i,
  input  wire cfg_t        cfg_i,
  input  wire entry_stat_t stat_i,
  output entry_ctl_t       ctl_o,
  output result_t          res_o
);

  mode_e              mode_q, mode_d;
  logic [PulseW-1:0]  pulse_q, pulse_d, pulse_inc;
  logic [LimitW-1:0]  poll_q, poll_d, poll_inc;
  logic               blink_q, blink_d;
  logic               armed_done;
  logic               budget_out;

  assign pulse_inc  = pulse_q + 1'b1;
  assign poll_inc   = poll_q + 1'b1;
  assign armed_done = pulse_inc >= PulseW'(cfg_i.arm_pulses);
  assign budget_out = poll_inc >= cfg_i.breach_poll_limit;

  assign ctl_o.take  = fire_i && (mode_q == ModeEntry || mode_q == ModeBreach);
  assign ctl_o.clear = fire_i && mode_q == ModeArmed && sensed_i;

  // next state
  always_comb begin
    mode_d  = mode_q;
    pulse_d = pulse_q;
    poll_d  = poll_q;
    blink_d = blink_q;
    case (mode_q)
      ModeEntry: begin
        if (stat_i.verdict == VerdictMatch) begin
          mode_d  = ModeArming;
          pulse_d = '0;
          blink_d = 1'b0;
        end
      end
      ModeArming: begin
        blink_d = ~blink_q;
        if (blink_q) begin
          pulse_d = pulse_inc;
          if (armed_done) begin
            mode_d  = ModeArmed;
            pulse_d = '0;
          end
        end
      end
      ModeArmed: begin
        if (sensed_i) begin
          mode_d = ModeBreach;
          poll_d = '0;
        end
      end
      ModeBreach: begin
        if (stat_i.verdict == VerdictMatch) begin
          mode_d = ModeHalt;
        end else if (stat_i.verdict == VerdictWrong) begin
          mode_d  = ModeSiren;
          blink_d = 1'b0;
        end else begin
          poll_d = poll_inc;
          if (budget_out) begin
            mode_d  = ModeSiren;
            blink_d = 1'b0;
          end
        end
      end
      ModeSiren: begin
        blink_d = ~blink_q;
      end
      ModeHalt: begin
        mode_d = ModeHalt;
      end
      default: begin
        mode_d = ModeHalt;
      end
    endcase
  end

  // result of this poll
  always_comb begin
    res_o      = '0;
    res_o.mode = mode_d;
    case (mode_q)
      ModeEntry: begin
        res_o.alarm_lamp = 1'b1;
        if (stat_i.verdict == VerdictMatch) begin
          res_o.message = MsgAccepted;
        end else if (stat_i.verdict == VerdictWrong) begin
          res_o.message = MsgWrong;
        end
        if (mode_d == ModeEntry) begin
          res_o.digits_entered = DigitsW'(stat_i.count);
        end
      end
      ModeArming: begin
        res_o.alarm_lamp = ~blink_q;
        res_o.low_buzzer = ~blink_q;
      end
      ModeArmed: begin
        res_o.alarm_lamp = 1'b1;
        res_o.zone_lamps = 1'b1;
        if (sensed_i) begin
          res_o.message = MsgBreach;
        end
      end
      ModeBreach: begin
        res_o.alarm_lamp = 1'b1;
        res_o.zone_lamps = 1'b1;
        res_o.low_buzzer = 1'b1;
        if (stat_i.verdict == VerdictMatch) begin
          res_o.message = MsgDisarmed;
        end else if (stat_i.verdict == VerdictWrong) begin
          res_o.message = MsgWrong;
        end else if (budget_out) begin
          res_o.message = MsgBreach;
        end
        if (mode_d == ModeBreach) begin
          res_o.digits_entered = DigitsW'(stat_i.count);
        end
      end
      ModeSiren: begin
        res_o.alarm_lamp   = ~blink_q;
        res_o.zone_lamps   = ~blink_q;
        res_o.high_buzzer  = ~blink_q;
        res_o.serial_alarm = ~blink_q;
      end
      default: begin
        res_o.message = MsgNone;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeEntry;
      pulse_q <= '0;
      poll_q  <= '0;
      blink_q <= 1'b0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      pulse_q <= pulse_d;
      poll_q  <= poll_d;
      blink_q <= blink_d;
    end
  end

  `KCAC_ASSERT_IMPL(a_blink_idle, (mode_q == ModeEntry || mode_q == ModeArmed || mode_q == ModeBreach), !blink_q, "blink phase set outside arming or siren")
  `KCAC_ASSERT_IMPL(a_pulse_idle, (mode_q != ModeArming), pulse_q == '0, "pulse count left over outside arming")
  `KCAC_ASSERT_NEXT(a_halt_final, (fire_i && mode_q == ModeHalt), mode_q == ModeHalt, "left disarmed halt")

endmodule

`default_nettype wire

// File: hdl/keypad_code_alarm_controller_unit.sv
// ----------------------------------------------------------------------------
// keypad_code_alarm_controller_unit
// Keypad code alarm controller: one poll request in, one result request out.
// ----------------------------------------------------------------------------
// A result is valid in the cycle after its poll request is accepted.
// Throughput: one poll per cycle; the mode logic is a single stage ahead of
// the result register, which takes a new poll while its result is taken.
// Configuration writes are always ready and take effect on the next poll.
// Reset: entry mode, empty code entry, counters and blink phase cleared,
// configuration back to its default values, no result pending.
`default_nettype none
`include "assert_macros.svh"

module keypad_code_alarm_controller_unit
  import kcac_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  kcac_cfg_if.sink    cfg_i,
  kcac_in_if.sink     in_i,
  kcac_out_if.source  out_o
);

  cfg_t        cfg;
  entry_ctl_t  ctl;
  entry_stat_t stat;
  result_t     res;
  result_t     res_q;
  logic        out_valid_q, out_valid_d;
  logic        in_ready;
  logic        fire;

  assign in_ready    = !out_valid_q || out_o.ready;
  assign fire        = in_i.valid && in_ready;
  assign in_i.ready  = in_ready;
  assign out_valid_d = fire || (out_valid_q && !out_o.ready);

  kcac_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  kcac_entry u_entry (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .key_i         (in_i.key),
    .secret_code_i (cfg.secret_code),
    .stat_o        (stat)
  );

  kcac_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .sensed_i (in_i.motion_sensor || in_i.door_sensor),
    .cfg_i    (cfg),
    .stat_i   (stat),
    .ctl_o    (ctl),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.mode           = res_q.mode;
  assign out_o.alarm_lamp     = res_q.alarm_lamp;
  assign out_o.zone_lamps     = res_q.zone_lamps;
  assign out_o.low_buzzer     = res_q.low_buzzer;
  assign out_o.high_buzzer    = res_q.high_buzzer;
  assign out_o.serial_alarm   = res_q.serial_alarm;
  assign out_o.message        = res_q.message;
  assign out_o.digits_entered = res_q.digits_entered;

  `KCAC_ASSERT_IMPL(a_no_overrun, (out_valid_q && !out_o.ready), !in_ready, "poll taken over a stalled result")
  `KCAC_ASSERT_IMPL(a_digits_mode, (out_valid_q && res_q.mode != ModeEntry && res_q.mode != ModeBreach), res_q.digits_entered == '0, "digit count outside code entry")
  `KCAC_ASSERT_IMPL(a_siren_mode, (out_valid_q && res_q.high_buzzer), res_q.mode == ModeSiren, "siren tone outside siren mode")
  `KCAC_ASSERT_IMPL(a_disarm_mode, (out_valid_q && res_q.message == MsgDisarmed), res_q.mode == ModeHalt, "disarmed message without halt")

endmodule

`default_nettype wire

// File: tb/sv/kcac_alarm_checker.sv
// ----------------------------------------------------------------------------
// kcac_alarm_checker
// Watches the poll, result and register channels of the alarm controller,
// keeps its own copy of the mode logic and registers, and compares every
// result request field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module kcac_alarm_checker
  import kcac_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  kcac_cfg_if   cfg_i,
  kcac_in_if    poll_i,
  kcac_out_if   result_i,
  output int    errors_o,
  output int    backlog_o,
  output mode_e model_mode_o
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t              settings;
  mode_e             alarm_mode;
  logic [KeyW-1:0]   held_keys [CodeDigits];
  logic [CntW-1:0]   held_cnt;
  logic [PulseW-1:0] pulse_cnt;
  logic [LimitW-1:0] poll_cnt;
  logic              blink;
  result_t           due_results [$];

  assign model_mode_o = alarm_mode;

  task automatic report(input string text);
    errors_o++;
    $display("%0t ns: %s", $realtime, text);
  endtask

  task automatic check_field(input string name, input logic [2:0] got, input logic [2:0] want);
    if (got !== want) begin
      report($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
    end
  endtask

  function automatic verdict_e press_key(input logic [KeyW-1:0] key);
    verdict_e    v;
    logic        same;
    int unsigned sh;
    int unsigned i;
    v = VerdictNone;
    if (key == KeyHash) begin
      held_cnt = '0;
    end else if (key != KeyNone) begin
      if (held_cnt >= CodeDigits) begin
        held_cnt = '0;
        if (key == KeyStar) begin
          same = 1'b1;
          for (i = 0; i < CodeDigits; i++) begin
            sh = 4 * (CodeDigits - 1 - i);
            if (sh >= CodeW) begin
              if (held_keys[i] != 4'h0) same = 1'b0;
            end else if (held_keys[i] != 4'(settings.secret_code >> sh)) begin
              same = 1'b0;
            end
          end
          v = same ? VerdictMatch : VerdictWrong;
        end
      end else begin
        held_keys[held_cnt] = key;
        held_cnt = held_cnt + 1'b1;
      end
    end
    return v;
  endfunction

  function automatic result_t step_alarm(input logic [KeyW-1:0] key, input logic sensed);
    result_t  r;
    verdict_e v;
    r = '0;
    case (alarm_mode)
      ModeEntry: begin
        r.alarm_lamp = 1'b1;
        v = press_key(key);
        if (v == VerdictMatch) begin
          r.message  = MsgAccepted;
          alarm_mode = ModeArming;
          pulse_cnt  = '0;
          blink      = 1'b0;
        end else if (v == VerdictWrong) begin
          r.message = MsgWrong;
        end
        if (alarm_mode == ModeEntry) r.digits_entered = DigitsW'(held_cnt);
      end
      ModeArming: begin
        r.alarm_lamp = ~blink;
        r.low_buzzer = ~blink;
        if (blink) begin
          pulse_cnt = pulse_cnt + 1'b1;
          if (pulse_cnt >= PulseW'(settings.arm_pulses)) begin
            alarm_mode = ModeArmed;
            pulse_cnt  = '0;
          end
        end
        blink = ~blink;
        if (alarm_mode == ModeArmed) blink = 1'b0;
      end
      ModeArmed: begin
        r.alarm_lamp = 1'b1;
        r.zone_lamps = 1'b1;
        if (sensed) begin
          r.message  = MsgBreach;
          alarm_mode = ModeBreach;
          held_cnt   = '0;
          poll_cnt   = '0;
        end
      end
      ModeBreach: begin
        r.alarm_lamp = 1'b1;
        r.zone_lamps = 1'b1;
        r.low_buzzer = 1'b1;
        v = press_key(key);
        if (v == VerdictMatch) begin
          r.message  = MsgDisarmed;
          alarm_mode = ModeHalt;
        end else if (v == VerdictWrong) begin
          r.message  = MsgWrong;
          alarm_mode = ModeSiren;
          blink      = 1'b0;
        end else begin
          poll_cnt = poll_cnt + 1'b1;
          if (poll_cnt >= settings.breach_poll_limit) begin
            r.message  = MsgBreach;
            alarm_mode = ModeSiren;
            blink      = 1'b0;
          end
        end
        if (alarm_mode == ModeBreach) r.digits_entered = DigitsW'(held_cnt);
      end
      ModeSiren: begin
        r.alarm_lamp   = ~blink;
        r.zone_lamps   = ~blink;
        r.high_buzzer  = ~blink;
        r.serial_alarm = ~blink;
        blink = ~blink;
      end
      default: begin
        alarm_mode = ModeHalt;
      end
    endcase
    r.mode = alarm_mode;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    result_t want;
    if (!rst_ni) begin
      settings.secret_code       = SecretCodeRst;
      settings.arm_pulses        = ArmPulsesRst;
      settings.breach_poll_limit = PollLimitRst;
      alarm_mode = ModeEntry;
      held_keys  = '{default: '0};
      held_cnt   = '0;
      pulse_cnt  = '0;
      poll_cnt   = '0;
      blink      = 1'b0;
      errors_o   = 0;
      due_results.delete();
    end else begin
      if (result_i.valid && result_i.ready) begin
        if (due_results.size() == 0) begin
          report($sformatf("result request with nothing expected, mode %0d", result_i.mode));
        end else begin
          want = due_results.pop_front();
          check_field("mode", result_i.mode, want.mode);
          check_field("alarm_lamp", 3'(result_i.alarm_lamp), 3'(want.alarm_lamp));
          check_field("zone_lamps", 3'(result_i.zone_lamps), 3'(want.zone_lamps));
          check_field("low_buzzer", 3'(result_i.low_buzzer), 3'(want.low_buzzer));
          check_field("high_buzzer", 3'(result_i.high_buzzer), 3'(want.high_buzzer));
          check_field("serial_alarm", 3'(result_i.serial_alarm), 3'(want.serial_alarm));
          check_field("message", result_i.message, want.message);
          check_field("digits_entered", result_i.digits_entered, want.digits_entered);
        end
      end
      if (poll_i.valid && poll_i.ready) begin
        due_results.push_back(step_alarm(poll_i.key, poll_i.motion_sensor | poll_i.door_sensor));
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CfgSecretCode: settings.secret_code       = cfg_i.data;
          CfgArmPulses:  settings.arm_pulses        = cfg_i.data[LimitW-1:0];
          CfgPollLimit:  settings.breach_poll_limit = cfg_i.data[LimitW-1:0];
          default: ;
        endcase
      end
    end
    backlog_o = due_results.size();
  end

endmodule

// File: tb/sv/keypad_code_alarm_controller_unit_tb.sv
// ----------------------------------------------------------------------------
// keypad_code_alarm_controller_unit_tb
// Drives poll and register requests into the alarm controller with random
// gaps and result stalls: a directed pass over the keypad corner cases, long
// code-entry phases under several secret codes, then one walk through
// arming, breach and a final siren or disarm. Checking is done by the
// checker instance; this module gives the verdict.
// ----------------------------------------------------------------------------
module keypad_code_alarm_controller_unit_tb;
  import kcac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic  clk_i  = 1'b0;
  logic  rst_ni = 1'b0;
  int    errors;
  int    backlog;
  mode_e model_mode;

  bit              tx_idle_en = 1'b1;
  bit              rx_idle_en = 1'b1;
  bit              guard_on   = 1'b1;
  logic [CodeW-1:0] code_now  = SecretCodeRst;
  logic [KeyW-1:0]  entry_keys [4];
  int              entry_held = 0;
  int              polls_sent = 0;

  kcac_in_if  poll_if ();
  kcac_out_if result_if ();
  kcac_cfg_if cfg_if ();

  keypad_code_alarm_controller_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (poll_if),
    .out_o  (result_if)
  );

  kcac_alarm_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_if),
    .poll_i       (poll_if),
    .result_i     (result_if),
    .errors_o     (errors),
    .backlog_o    (backlog),
    .model_mode_o (model_mode)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic coin();
    return 1'($urandom);
  endfunction

  // any key that lands in the entry buffer: digits, star and 12..14
  function automatic logic [KeyW-1:0] enterable_key();
    logic [KeyW-1:0] k;
    k = 4'($urandom_range(0, 13));
    return (k >= KeyHash) ? k + 4'd1 : k;
  endfunction

  // any key but star, so no code check is triggered
  function automatic logic [KeyW-1:0] quiet_key();
    logic [KeyW-1:0] k;
    k = 4'($urandom_range(0, 14));
    return (k >= KeyStar) ? k + 4'd1 : k;
  endfunction

  function automatic logic [CodeW-1:0] entry_code();
    return {enterable_key(), enterable_key(), enterable_key(), enterable_key()};
  endfunction

  function automatic logic [CodeW-1:0] near_miss(input logic [CodeW-1:0] code);
    int unsigned     pos;
    logic [KeyW-1:0] k;
    pos = $urandom_range(0, 3);
    do k = enterable_key(); while (k == code[4*pos +: 4]);
    code[4*pos +: 4] = k;
    return code;
  endfunction

  // called at a falling edge; returns at a falling edge with valid low
  task automatic send_poll(input logic [KeyW-1:0] key, input logic motion, input logic door);
    logic [KeyW-1:0] k;
    k = key;
    if (guard_on) begin
      // keep the unit in entry mode: a matching star becomes a hash
      if (k == KeyStar && entry_held == 4 &&
          {entry_keys[0], entry_keys[1], entry_keys[2], entry_keys[3]} == code_now) begin
        k = KeyHash;
      end
      if (k == KeyHash) begin
        entry_held = 0;
      end else if (k != KeyNone) begin
        if (entry_held >= 4) begin
          entry_held = 0;
        end else begin
          entry_keys[entry_held] = k;
          entry_held++;
        end
      end
    end
    if (tx_idle_en && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) @(negedge clk_i);
    poll_if.valid         = 1'b1;
    poll_if.key           = k;
    poll_if.motion_sensor = motion;
    poll_if.door_sensor   = door;
    do @(posedge clk_i); while (poll_if.ready !== 1'b1);
    @(negedge clk_i);
    poll_if.valid = 1'b0;
    polls_sent++;
  endtask

  task automatic send_attempt(input logic [CodeW-1:0] digits);
    int i;
    for (i = 3; i >= 0; i--) begin
      if ($urandom_range(0, 3) == 0) send_poll(KeyNone, coin(), coin());
      send_poll(digits[4*i +: 4], coin(), coin());
    end
    send_poll(KeyStar, coin(), coin());
  endtask

  task automatic wait_drained();
    while (backlog != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CodeW-1:0] data);
    wait_drained();
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
    if (idx == CfgSecretCode) code_now = data;
  endtask

  initial begin : result_sink
    int stall;
    stall = 0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        stall--;
        result_if.ready = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(0, 2);
        result_if.ready = 1'b0;
      end else begin
        result_if.ready = 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [KeyW-1:0] directed_keys [25];
    int p;
    int n;
    int target;
    int ending;
    bit long_arm;

    directed_keys = '{KeyNone, 1, 2, KeyHash,
                      KeyStar, 2, 5, 8, KeyStar,
                      1, 2, 5, 8, 3,
                      12, 13, 14, 0, KeyStar,
                      9, 0, KeyNone, 9, 0, KeyStar};
    poll_if.valid         = 1'b0;
    poll_if.key           = KeyNone;
    poll_if.motion_sensor = 1'b0;
    poll_if.door_sensor   = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = CfgSecretCode;
    cfg_if.data           = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // keypad corner cases under the default code
    foreach (directed_keys[i]) send_poll(directed_keys[i], coin(), coin());

    for (p = 0; p < 6; p++) begin
      case (p)
        0: write_reg(CfgSecretCode, 16'h0000);
        1: write_reg(CfgSecretCode, 16'hFFFF);
        2: write_reg(CfgSecretCode, 16'hAAAA);
        3: write_reg(CfgSecretCode, 16'($urandom));
        default: write_reg(CfgSecretCode, entry_code());
      endcase
      if (p == 1) begin
        write_reg(CfgArmPulses, 16'hFFFF);
        write_reg(CfgPollLimit, 16'h00FF);
      end
      if (p == 2) begin
        write_reg(CfgArmPulses, 16'h0001);
        write_reg(CfgPollLimit, 16'hFF01);
      end
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      target = polls_sent + 280;
      while (polls_sent < target) begin
        case ($urandom_range(0, 9))
          0, 1, 2: send_attempt(near_miss(code_now));
          3, 4:    send_attempt(entry_code());
          5:       send_attempt(code_now);
          default: send_poll(4'($urandom), coin(), coin());
        endcase
      end
    end

    // one pass through arming, breach and a terminal mode
    tx_idle_en = ($urandom_range(0, 3) != 0);
    rx_idle_en = ($urandom_range(0, 3) != 0);
    write_reg(CfgSecretCode, entry_code());
    long_arm = ($urandom_range(0, 3) == 0);
    write_reg(CfgArmPulses, long_arm ? 16'h00FF : 16'($urandom_range(1, 6)));
    ending = $urandom_range(0, 2);
    if (ending == 2) begin
      write_reg(CfgPollLimit, ($urandom_range(0, 1) == 0) ? 16'd1 : 16'($urandom_range(2, 20)));
    end else begin
      write_reg(CfgPollLimit, {8'($urandom), 8'hFF});
    end
    send_poll(KeyHash, coin(), coin());
    guard_on = 1'b0;
    send_attempt(code_now);

    n = 0;
    while (model_mode == ModeArming) begin
      if (long_arm && n == 40) write_reg(CfgArmPulses, 16'd1);
      send_poll(4'($urandom), coin(), coin());
      n++;
    end

    repeat ($urandom_range(0, 6)) send_poll(4'($urandom), 1'b0, 1'b0);
    case ($urandom_range(0, 2))
      0:       send_poll(4'($urandom), 1'b1, 1'b0);
      1:       send_poll(4'($urandom), 1'b0, 1'b1);
      default: send_poll(4'($urandom), 1'b1, 1'b1);
    endcase

    case (ending)
      0: begin
        repeat ($urandom_range(0, 5)) send_poll(quiet_key(), coin(), coin());
        send_poll(KeyHash, coin(), coin());
        send_attempt(code_now);
      end
      1: begin
        send_poll(KeyHash, coin(), coin());
        send_attempt(near_miss(code_now));
      end
      default: begin
        while (model_mode == ModeBreach) send_poll(quiet_key(), coin(), coin());
      end
    endcase

    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (60) send_poll(4'($urandom), coin(), coin());

    for (n = 0; n < 1000 && backlog != 0; n++) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (errors == 0 && backlog == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
